>>> rtl/interrupt_controller_with_sub_sources_unit_assert.svh
// Assertion macros used by the interrupt controller top module.
// Each takes a label, an antecedent and a consequent, sampled on clk
// and disabled while rst is high.
`ifndef INTERRUPT_CONTROLLER_WITH_SUB_SOURCES_UNIT_ASSERT_SVH
`define INTERRUPT_CONTROLLER_WITH_SUB_SOURCES_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ICSS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("icss same-cycle check failed");
`define ICSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("icss next-cycle check failed");
`else
`define ICSS_ASSERT_SAME(label, ante, cons)
`define ICSS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/icss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package icss_pkg;

  localparam int unsigned NUM_MAIN = 32;
  localparam logic [3:0]  SUB_COUNT = 4'd11;

  localparam logic [31:0] MAIN_MASK_RESET = 32'hFFFF_FFFF;
  localparam logic [31:0] PRIORITY_RESET  = 32'h0000_007F;
  localparam logic [31:0] SUB_MASK_RESET  = 32'h0000_07FF;

  // sub source groups and the main bit each group feeds
  localparam logic [10:0] GRP0_SUBS = 11'h007;
  localparam logic [10:0] GRP1_SUBS = 11'h038;
  localparam logic [10:0] GRP2_SUBS = 11'h1C0;
  localparam logic [10:0] GRP3_SUBS = 11'h600;
  localparam logic [4:0]  GRP0_MAIN = 5'd28;
  localparam logic [4:0]  GRP1_MAIN = 5'd23;
  localparam logic [4:0]  GRP2_MAIN = 5'd15;
  localparam logic [4:0]  GRP3_MAIN = 5'd31;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_MAIN  = 2'd2,
    MODE_SUB   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    SLOT_SRCPND    = 3'd0,
    SLOT_INTMOD    = 3'd1,
    SLOT_INTMSK    = 3'd2,
    SLOT_PRIORITY  = 3'd3,
    SLOT_INTPND    = 3'd4,
    SLOT_INTOFFSET = 3'd5,
    SLOT_SUBSRCPND = 3'd6,
    SLOT_INTSUBMSK = 3'd7
  } slot_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_OFFSET = 3'd1,
    ST_FIQ        = 3'd2,
    ST_BAD_SUB    = 3'd3,
    ST_MISMATCH   = 3'd4
  } status_t;

  typedef struct packed {
    logic [31:0] source_pending;
    logic [31:0] fiq_mode_bits;
    logic [31:0] irq_mask;
    logic [31:0] priority_word;
    logic [31:0] winner_pending;
    logic [4:0]  winner_offset;
    logic [10:0] sub_pending;
    logic [31:0] sub_mask_word;
  } state_t;

  localparam state_t STATE_RESET = '{
    source_pending: 32'h0,
    fiq_mode_bits:  32'h0,
    irq_mask:       MAIN_MASK_RESET,
    priority_word:  PRIORITY_RESET,
    winner_pending: 32'h0,
    winner_offset:  5'd0,
    sub_pending:    11'h0,
    sub_mask_word:  SUB_MASK_RESET
  };

  typedef struct packed {
    mode_t       mode;
    logic [19:0] offset;
    logic [31:0] write_data;
    logic [4:0]  source;
    logic [3:0]  sub_source;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    status_t     status;
    logic        irq_line;
    logic [10:0] cleared_sub_bits;
    logic [31:0] cleared_main_bits;
  } result_t;

  function automatic logic [31:0] rollup(input logic [10:0] active);
    logic [31:0] m;
    m = '0;
    if ((active & GRP0_SUBS) != '0) m[GRP0_MAIN] = 1'b1;
    if ((active & GRP1_SUBS) != '0) m[GRP1_MAIN] = 1'b1;
    if ((active & GRP2_SUBS) != '0) m[GRP2_MAIN] = 1'b1;
    if ((active & GRP3_SUBS) != '0) m[GRP3_MAIN] = 1'b1;
    return m;
  endfunction

  // only called with sub < SUB_COUNT
  function automatic logic [4:0] owner_of(input logic [3:0] sub);
    logic [15:0] bit_sel;
    logic [4:0]  owner;
    bit_sel = 16'(1) << sub;
    owner = GRP3_MAIN;
    if ((bit_sel[10:0] & GRP0_SUBS) != '0) owner = GRP0_MAIN;
    else if ((bit_sel[10:0] & GRP1_SUBS) != '0) owner = GRP1_MAIN;
    else if ((bit_sel[10:0] & GRP2_SUBS) != '0) owner = GRP2_MAIN;
    return owner;
  endfunction

  function automatic logic [4:0] encode32(input logic [31:0] onehot);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < NUM_MAIN; i++) begin
      if (onehot[i]) r = r | 5'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/interrupt_controller_with_sub_sources_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | handshake          | word
// ---------+--------------------+--------------------------------------------
// in       | in_valid/in_ready  | mode, offset, write_data, source, sub_source
// out      | out_valid/out_ready| read_data, status, irq_line, cleared_*_bits
//
// One word per cycle sustained while out_ready keeps the output free; a word
// passes the input register, then the state and result registers, which load together.
// Register state changes only when the result register loads, so a stalled
// output holds the input register and the state. Synchronous reset restores
// the register reset values; no clearing pass.
module interrupt_controller_with_sub_sources_unit import icss_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [19:0] offset,
  input  wire logic [31:0] write_data,
  input  wire logic [4:0]  source,
  input  wire logic [3:0]  sub_source,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      read_data,
  output logic [2:0]       status,
  output logic             irq_line,
  output logic [10:0]      cleared_sub_bits,
  output logic [31:0]      cleared_main_bits
);

`include "interrupt_controller_with_sub_sources_unit_assert.svh"

  item_t   item_q;
  logic    item_valid;
  state_t  st;
  state_t  st_next;
  result_t res_next;
  result_t res_q;
  logic    out_free;
  logic    advance;

  assign out_free = !out_valid || out_ready;
  assign advance  = item_valid && out_free;
  assign in_ready = !item_valid || out_free;

  icss_step u_step (
    .st      (st),
    .item    (item_q),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= '{mode: mode_t'(mode), offset: offset, write_data: write_data,
                  source: source, sub_source: sub_source};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign read_data         = res_q.read_data;
  assign status            = res_q.status;
  assign irq_line          = res_q.irq_line;
  assign cleared_sub_bits  = res_q.cleared_sub_bits;
  assign cleared_main_bits = res_q.cleared_main_bits;

  // a shown result always matches the current state, since both load together
  `ICSS_ASSERT_SAME(a_irq_tracks_state, out_valid,
    irq_line == ((st.source_pending & ~st.irq_mask) != '0))
  `ICSS_ASSERT_SAME(a_winner_onehot, 1'b1, $onehot0(st.winner_pending))
  `ICSS_ASSERT_NEXT(a_error_keeps_state, advance && (res_next.status != ST_OK),
    $stable(st))
  `ICSS_ASSERT_SAME(a_error_zero_data, out_valid && (res_q.status != ST_OK),
    (read_data == '0) && (cleared_sub_bits == '0) && (cleared_main_bits == '0))

endmodule
`default_nettype wire

>>> rtl/icss_step.sv
`timescale 1ns / 1ps
`default_nettype none
module icss_step import icss_pkg::*; (
  input  state_t  st,
  input  item_t   item,
  output state_t  st_next,
  output result_t res
);

  logic        bad_offset;
  slot_t       slot;
  logic        do_roll;
  logic [31:0] wd;
  logic [31:0] live;

  assign bad_offset = (item.offset[19:5] != '0);
  assign slot       = slot_t'(item.offset[4:2]);
  assign wd         = item.write_data;

  always_comb begin
    st_next = st;
    res     = '0;
    res.status = ST_OK;
    do_roll = 1'b0;

    case (item.mode)
      MODE_READ: begin
        if (bad_offset) begin
          res.status = ST_BAD_OFFSET;
        end else begin
          case (slot)
            SLOT_SRCPND:    res.read_data = st.source_pending;
            SLOT_INTMOD:    res.read_data = st.fiq_mode_bits;
            SLOT_INTMSK:    res.read_data = st.irq_mask;
            SLOT_PRIORITY:  res.read_data = st.priority_word;
            SLOT_INTPND:    res.read_data = st.winner_pending;
            SLOT_INTOFFSET: res.read_data = {27'h0, st.winner_offset};
            SLOT_SUBSRCPND: res.read_data = {21'h0, st.sub_pending};
            SLOT_INTSUBMSK: res.read_data = st.sub_mask_word;
            default:        res.read_data = '0;
          endcase
        end
      end
      MODE_WRITE: begin
        if (bad_offset) begin
          res.status = ST_BAD_OFFSET;
        end else begin
          case (slot)
            SLOT_SRCPND: begin
              res.cleared_main_bits  = st.source_pending & wd;
              st_next.source_pending = st.source_pending & ~wd;
              do_roll = 1'b1;
            end
            SLOT_INTMOD:   st_next.fiq_mode_bits = wd;
            SLOT_INTMSK:   st_next.irq_mask      = wd;
            SLOT_PRIORITY: st_next.priority_word = wd;
            SLOT_SUBSRCPND: begin
              res.cleared_sub_bits = st.sub_pending & wd[10:0];
              st_next.sub_pending  = st.sub_pending & ~wd[10:0];
              do_roll = 1'b1;
            end
            SLOT_INTSUBMSK: begin
              st_next.sub_mask_word = wd;
              do_roll = 1'b1;
            end
            // pending word and offset are rebuilt below; offset is read-only
            default: ;
          endcase
        end
      end
      MODE_MAIN: begin
        if (st.fiq_mode_bits[item.source]) begin
          res.status = ST_FIQ;
        end else begin
          st_next.source_pending = st.source_pending | (32'(1) << item.source);
        end
      end
      MODE_SUB: begin
        if (item.sub_source >= SUB_COUNT) begin
          res.status = ST_BAD_SUB;
        end else if (st.fiq_mode_bits[item.source]) begin
          res.status = ST_FIQ;
        end else if (owner_of(item.sub_source) != item.source) begin
          res.status = ST_MISMATCH;
        end else begin
          st_next.sub_pending = st.sub_pending | (11'(1) << item.sub_source);
          do_roll = 1'b1;
        end
      end
      default: res.status = ST_OK;
    endcase

    if (do_roll) begin
      st_next.source_pending = st_next.source_pending |
        rollup(st_next.sub_pending & ~st_next.sub_mask_word[10:0]);
    end

    // lowest live bit wins: isolate it with x & -x
    live = st_next.source_pending & ~st_next.irq_mask;
    st_next.winner_pending = live & (~live + 32'd1);
    st_next.winner_offset  = encode32(st_next.winner_pending);
    res.irq_line = (live != '0);
  end

endmodule
`default_nettype wire
